>>> design/pwmsr_pkg.sv
// ----------------------------------------------------------------------------
// pwmsr_pkg: shared types and constants of the soft ramp controller
// Field widths, event codes, the classified event carried between front end
// and back end, and the fixed constants of the speed to duty mapping.
// ----------------------------------------------------------------------------
package pwmsr_pkg;

   // field widths
   localparam int OP_W       = 3;
   localparam int REQ_W      = 8;
   localparam int PULSE_W    = 15;
   localparam int CMP_W      = 10;
   localparam int DUTY_W     = 7;
   localparam int SPEED_W    = 7;
   localparam int MODE_W     = 2;
   localparam int RPM_W      = 16;
   localparam int IDX_W      = 5;
   localparam int STOP_IDX_W = 4;

   // speed to duty mapping
   localparam int unsigned DUTY_SLOW   = 90;
   localparam int unsigned DUTY_FAST   = 10;
   localparam int unsigned DUTY_OFF    = 100;
   localparam int unsigned MIN_SPEED   = 8;
   localparam int unsigned SPEED_MAX   = 100;
   localparam int unsigned PCT_SPAN    = 99;
   localparam int unsigned STOP_POINTS = 10;
   localparam int unsigned SEC_PER_MIN = 60;

   // reciprocal multiply for the ramp and stop interpolation
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP_W     = 19;
   localparam int ACC_W       = 12;
   localparam int STOP_ACC_W  = 10;
   localparam int PROD_W      = ACC_W + RECIP_W;

   // reciprocal multiply for the rpm conversion, split in two halves
   localparam int RPM_SHIFT  = 27;
   localparam int RPM_X_W    = PULSE_W + 6;
   localparam int RPM_HALF_W = 14;
   localparam int RPM_PP_W   = RPM_X_W + RPM_HALF_W;
   localparam int RPM_SUM_W  = RPM_PP_W + RPM_HALF_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_SET_SPEED  = 3'd0,
      OP_START      = 3'd1,
      OP_STOP       = 3'd2,
      OP_RAMP_TICK  = 3'd3,
      OP_STOP_TICK  = 3'd4,
      OP_RPM_WINDOW = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_SET_SPEED,
      KIND_START,
      KIND_STOP,
      KIND_RAMP_TICK,
      KIND_STOP_TICK,
      KIND_RPM
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [SPEED_W-1:0]     speed;
      logic [DUTY_W-1:0]      speed_duty;
      logic [RPM_W-1:0]       rpm;
   } event_type;

endpackage

>>> design/pwmsr_if.sv
// ----------------------------------------------------------------------------
// pwmsr_if: request and response channels of the soft ramp controller
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface pwmsr_req_if
   import pwmsr_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [REQ_W-1:0]     speed_request;
   logic [PULSE_W-1:0]   pulse_count;

   modport source (output valid, output op, output speed_request, output pulse_count,
                   input ready);
   modport sink   (input valid, input op, input speed_request, input pulse_count,
                   output ready);
endinterface

interface pwmsr_rsp_if
   import pwmsr_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CMP_W-1:0]     compare_value;
   logic [DUTY_W-1:0]    duty_percent;
   logic [MODE_W-1:0]    mode;
   logic                 mode_changed;
   logic [SPEED_W-1:0]   speed_now;
   logic [RPM_W-1:0]     rpm_value;
   logic                 pwm_running;

   modport source (output valid, output compare_value, output duty_percent, output mode,
                   output mode_changed, output speed_now, output rpm_value,
                   output pwm_running, input ready);
   modport sink   (input valid, input compare_value, input duty_percent, input mode,
                   input mode_changed, input speed_now, input rpm_value,
                   input pwm_running, output ready);
endinterface

>>> design/pwm_motor_soft_ramp_controller.sv
// A result passes through the front stage register, the queue and the result register.
// One item per cycle while results are taken; the back end's single reciprocal multiply
// settles each event combinationally, and the front end's split rpm product is pipelined
// ahead of the queue.
// Reset (synchronous, active high): mode stopped, duty 100, speeds and rpm 0,
// timer off, queue and result register empty.
// ----------------------------------------------------------------------------
// pwm_motor_soft_ramp_controller: soft start and speed ramp for a PWM motor
// Front end classifies events and converts rpm, a two-entry queue decouples
// it from the back end, which sequences the ramps and registers the result.
// ----------------------------------------------------------------------------
module pwm_motor_soft_ramp_controller
   import pwmsr_pkg::*;
#(
   parameter int unsigned PWM_PERIOD     = 1000,
   parameter int unsigned PULSES_PER_REV = 2,
   parameter int unsigned START_STEPS    = 10,
   parameter int unsigned SPEED_STEPS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   pwmsr_req_if.sink   req,
   pwmsr_rsp_if.source rsp
);

   // front end to queue
   logic       push;
   event_type  push_data;
   logic       q_full;

   // queue to back end
   logic       pop;
   logic       q_valid;
   event_type  q_data;

   // Accept, clamp the speed, look up its duty, and convert the pulse count.
   // The front stage holds whenever its event cannot enter the queue.
   pwmsr_front #(
      .PULSES_PER_REV (PULSES_PER_REV)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   // Buffer classified items so that a stalled result does not block intake.
   pwmsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // Advance the mode and the ramp, and present one result per item.
   pwmsr_back #(
      .PWM_PERIOD  (PWM_PERIOD),
      .START_STEPS (START_STEPS),
      .SPEED_STEPS (SPEED_STEPS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

>>> design/pwmsr_front.sv
// ----------------------------------------------------------------------------
// pwmsr_front: accept and classify events
// Registers each request, clamps the speed, looks up its duty and converts
// the pulse count to rpm, then hands a classified event to the queue.
// ----------------------------------------------------------------------------
module pwmsr_front
   import pwmsr_pkg::*;
#(
   parameter int unsigned PULSES_PER_REV = 2
) (
   input  logic           clock,
   input  logic           reset,
   pwmsr_req_if.sink      req,
   output logic           push,
   output event_type      push_data,
   input  logic           q_full
);

   localparam int unsigned RPM_RECIP = ((1 << RPM_SHIFT) + PULSES_PER_REV - 1) / PULSES_PER_REV;
   localparam logic [RPM_HALF_W-1:0] RPM_RECIP_LO = RPM_HALF_W'(RPM_RECIP % (1 << RPM_HALF_W));
   localparam logic [RPM_HALF_W-1:0] RPM_RECIP_HI = RPM_HALF_W'(RPM_RECIP / (1 << RPM_HALF_W));

   logic [DUTY_W-1:0]    duty_tab [2**SPEED_W];

   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;
   logic [RPM_PP_W-1:0]  pp_lo_ff, pp_lo_in;
   logic [RPM_PP_W-1:0]  pp_hi_ff, pp_hi_in;

   logic                 advance;
   logic [RPM_X_W-1:0]   rpm_x;
   logic [RPM_SUM_W-1:0] rpm_sum;
   logic [RPM_SUM_W-RPM_SHIFT-1:0] rpm_full;

   // speed to duty table, worked out at elaboration
   for (genvar g = 0; g < 2**SPEED_W; g++) begin : g_duty
      localparam int unsigned SP = (g > SPEED_MAX) ? SPEED_MAX : g;
      localparam int unsigned DT = (SP == 0) ? DUTY_OFF :
                                   DUTY_SLOW - ((SP - 1) * (DUTY_SLOW - DUTY_FAST)) / PCT_SPAN;
      assign duty_tab[g] = DUTY_W'(DT);
   end

   // hold the stage while its event cannot enter the queue
   assign advance   = !valid_ff || !q_full;
   assign req.ready = advance;
   assign valid_in  = req.valid;

   always_comb begin
      case (op_type'(req.op))
         OP_SET_SPEED:  kind_in = KIND_SET_SPEED;
         OP_START:      kind_in = KIND_START;
         OP_STOP:       kind_in = KIND_STOP;
         OP_RAMP_TICK:  kind_in = KIND_RAMP_TICK;
         OP_STOP_TICK:  kind_in = KIND_STOP_TICK;
         OP_RPM_WINDOW: kind_in = KIND_RPM;
         default:       kind_in = KIND_NONE;
      endcase

      if (req.speed_request > REQ_W'(SPEED_MAX)) begin
         speed_in = SPEED_W'(SPEED_MAX);
      end else if (req.speed_request != '0 && req.speed_request < REQ_W'(MIN_SPEED)) begin
         speed_in = SPEED_W'(MIN_SPEED);
      end else begin
         speed_in = req.speed_request[SPEED_W-1:0];
      end
      duty_in = duty_tab[speed_in];

      // pulses times sixty, then both halves of the reciprocal product
      rpm_x    = (RPM_X_W'(req.pulse_count) << 6) - (RPM_X_W'(req.pulse_count) << 2);
      pp_lo_in = RPM_PP_W'(rpm_x) * RPM_PP_W'(RPM_RECIP_LO);
      pp_hi_in = RPM_PP_W'(rpm_x) * RPM_PP_W'(RPM_RECIP_HI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         kind_ff  <= kind_in;
         speed_ff <= speed_in;
         duty_ff  <= duty_in;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
   end

   // combine the halves and saturate
   always_comb begin
      rpm_sum  = (RPM_SUM_W'(pp_hi_ff) << RPM_HALF_W) + RPM_SUM_W'(pp_lo_ff);
      rpm_full = rpm_sum[RPM_SUM_W-1:RPM_SHIFT];
      push_data.kind       = kind_ff;
      push_data.speed      = speed_ff;
      push_data.speed_duty = duty_ff;
      if (|rpm_full[RPM_SUM_W-RPM_SHIFT-1:RPM_W]) begin
         push_data.rpm = '1;
      end else begin
         push_data.rpm = rpm_full[RPM_W-1:0];
      end
   end

   assign push = valid_ff && !q_full;

endmodule

>>> design/pwmsr_queue.sv
// ----------------------------------------------------------------------------
// pwmsr_queue: two-entry event queue
// Decouples the front end from the back end so that each may stall alone.
// ----------------------------------------------------------------------------
module pwmsr_queue
   import pwmsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  event_type  push_data,
   output logic       full,
   input  logic       pop,
   output logic       pop_valid,
   output event_type  pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   event_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/pwmsr_back.sv
// ----------------------------------------------------------------------------
// pwmsr_back: mode sequencer and result register
// Carries out one classified event a cycle while the result register drains, against
// the ramp state, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pwmsr_back
   import pwmsr_pkg::*;
#(
   parameter int unsigned PWM_PERIOD  = 1000,
   parameter int unsigned START_STEPS = 10,
   parameter int unsigned SPEED_STEPS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  event_type      q_data,
   output logic           pop,
   pwmsr_rsp_if.source    rsp
);

   typedef enum logic [MODE_W-1:0] {
      ST_STOPPED = 2'd0,
      ST_UP      = 2'd1,
      ST_RUN     = 2'd2,
      ST_DOWN    = 2'd3
   } state_type;

   localparam logic [RECIP_W-1:0] RECIP_START =
      RECIP_W'(((1 << RECIP_SHIFT) + START_STEPS - 1) / START_STEPS);
   localparam logic [RECIP_W-1:0] RECIP_SPEED =
      RECIP_W'(((1 << RECIP_SHIFT) + SPEED_STEPS - 1) / SPEED_STEPS);
   localparam logic [RECIP_W-1:0] RECIP_STOP =
      RECIP_W'(((1 << RECIP_SHIFT) + STOP_POINTS - 1) / STOP_POINTS);

   logic [CMP_W-1:0] cmp_tab [2**DUTY_W];

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0]        compare_ff, compare_in;
   logic                    changed_ff, changed_in;
   logic [SPEED_W-1:0]      tgt_speed_ff, tgt_speed_in;
   logic [DUTY_W-1:0]       tgt_duty_ff, tgt_duty_in;
   logic [SPEED_W-1:0]      cur_speed_ff, cur_speed_in;
   logic [DUTY_W-1:0]       cur_duty_ff, cur_duty_in;
   logic [DUTY_W-1:0]       ramp_from_ff, ramp_from_in;
   logic [DUTY_W-1:0]       ramp_to_ff, ramp_to_in;
   logic [DUTY_W-1:0]       ramp_mag_ff, ramp_mag_in;
   logic                    ramp_neg_ff, ramp_neg_in;
   logic [ACC_W-1:0]        ramp_acc_ff, ramp_acc_in;
   logic [IDX_W-1:0]        ramp_idx_ff, ramp_idx_in;
   logic                    ramp_long_ff, ramp_long_in;
   logic [STOP_IDX_W-1:0]   stop_idx_ff, stop_idx_in;
   logic [DUTY_W-1:0]       stop_from_ff, stop_from_in;
   logic [STOP_ACC_W-1:0]   stop_acc_ff, stop_acc_in;
   logic [DUTY_W-1:0]       duty_ff, duty_in;
   logic [RPM_W-1:0]        rpm_ff, rpm_in;
   logic                    timer_ff, timer_in;

   logic [ACC_W-1:0]        ramp_sum;
   logic [STOP_ACC_W-1:0]   stop_sum;
   logic [ACC_W-1:0]        mul_x;
   logic [RECIP_W-1:0]      mul_m;
   logic [PROD_W-1:0]       product;
   logic [DUTY_W-1:0]       quot;
   logic [IDX_W-1:0]        ramp_steps;
   logic [IDX_W-1:0]        idx_next;
   logic [DUTY_W-1:0]       kick;
   logic [DUTY_W-1:0]       stop_start;

   // compare value of each duty, worked out at elaboration
   for (genvar g = 0; g < 2**DUTY_W; g++) begin : g_cmp
      localparam int unsigned DD = (g > DUTY_OFF) ? DUTY_OFF : g;
      localparam int unsigned CR = (PWM_PERIOD * (DUTY_OFF - DD)) / DUTY_OFF;
      localparam int unsigned CC = (CR < 1) ? 1 : ((CR >= PWM_PERIOD) ? PWM_PERIOD - 1 : CR);
      assign cmp_tab[g] = CMP_W'(CC);
   end

   // take the next event whenever the result register is free or drains
   assign pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      // shared interpolation: one reciprocal multiply serves ramp and stop
      ramp_sum   = ramp_acc_ff + ACC_W'(ramp_mag_ff);
      stop_sum   = stop_acc_ff + STOP_ACC_W'(DUTY_W'(DUTY_OFF) - stop_from_ff);
      ramp_steps = ramp_long_ff ? IDX_W'(SPEED_STEPS) : IDX_W'(START_STEPS);
      idx_next   = ramp_idx_ff + 1'b1;
      if (q_data.kind == KIND_STOP_TICK) begin
         mul_x = ACC_W'(stop_sum);
         mul_m = RECIP_STOP;
      end else begin
         mul_x = ramp_sum;
         mul_m = ramp_long_ff ? RECIP_SPEED : RECIP_START;
      end
      product    = PROD_W'(mul_x) * PROD_W'(mul_m);
      quot       = product[RECIP_SHIFT +: DUTY_W];
      kick       = (tgt_duty_ff < DUTY_W'(DUTY_FAST)) ? tgt_duty_ff : DUTY_W'(DUTY_FAST);
      stop_start = (cur_duty_ff > DUTY_W'(DUTY_SLOW)) ? DUTY_W'(DUTY_SLOW) : cur_duty_ff;

      state_in     = state_ff;
      tgt_speed_in = tgt_speed_ff;
      tgt_duty_in  = tgt_duty_ff;
      cur_speed_in = cur_speed_ff;
      cur_duty_in  = cur_duty_ff;
      ramp_from_in = ramp_from_ff;
      ramp_to_in   = ramp_to_ff;
      ramp_acc_in  = ramp_acc_ff;
      ramp_idx_in  = ramp_idx_ff;
      ramp_long_in = ramp_long_ff;
      stop_idx_in  = stop_idx_ff;
      stop_from_in = stop_from_ff;
      stop_acc_in  = stop_acc_ff;
      duty_in      = duty_ff;
      rpm_in       = rpm_ff;
      timer_in     = timer_ff;

      case (q_data.kind)
         KIND_SET_SPEED: begin
            tgt_speed_in = q_data.speed;
            tgt_duty_in  = q_data.speed_duty;
            if (state_ff == ST_UP || state_ff == ST_RUN) begin
               ramp_from_in = cur_duty_ff;
               ramp_to_in   = q_data.speed_duty;
               ramp_long_in = 1'b1;
               ramp_idx_in  = '0;
               ramp_acc_in  = '0;
               state_in     = ST_UP;
            end
         end
         KIND_START: begin
            if (state_ff == ST_STOPPED || state_ff == ST_UP) begin
               state_in     = ST_UP;
               duty_in      = kick;
               timer_in     = 1'b1;
               ramp_from_in = kick;
               ramp_to_in   = tgt_duty_ff;
               ramp_long_in = 1'b0;
               ramp_idx_in  = '0;
               ramp_acc_in  = '0;
            end
         end
         KIND_STOP: begin
            if (state_ff != ST_STOPPED) begin
               state_in     = ST_DOWN;
               stop_from_in = stop_start;
               duty_in      = stop_start;
               stop_idx_in  = STOP_IDX_W'(1);
               stop_acc_in  = '0;
            end
         end
         KIND_RAMP_TICK: begin
            if (state_ff == ST_UP) begin
               ramp_idx_in = idx_next;
               ramp_acc_in = ramp_sum;
               if (idx_next >= ramp_steps) begin
                  duty_in      = ramp_to_ff;
                  cur_speed_in = tgt_speed_ff;
                  cur_duty_in  = tgt_duty_ff;
                  state_in     = ST_RUN;
               end else if (ramp_neg_ff) begin
                  duty_in = ramp_from_ff - quot;
               end else begin
                  duty_in = ramp_from_ff + quot;
               end
            end
         end
         KIND_STOP_TICK: begin
            if (state_ff == ST_DOWN) begin
               if (stop_idx_ff <= STOP_IDX_W'(STOP_POINTS)) begin
                  stop_acc_in = stop_sum;
                  duty_in     = stop_from_ff + quot;
                  stop_idx_in = stop_idx_ff + 1'b1;
               end else begin
                  // final tick after the last point: halt the timer
                  timer_in     = 1'b0;
                  cur_speed_in = '0;
                  cur_duty_in  = DUTY_W'(DUTY_OFF);
                  rpm_in       = '0;
                  stop_idx_in  = '0;
                  state_in     = ST_STOPPED;
               end
            end
         end
         KIND_RPM: begin
            rpm_in = q_data.rpm;
         end
         default: begin
         end
      endcase

      if (ramp_to_in < ramp_from_in) begin
         ramp_neg_in = 1'b1;
         ramp_mag_in = ramp_from_in - ramp_to_in;
      end else begin
         ramp_neg_in = 1'b0;
         ramp_mag_in = ramp_to_in - ramp_from_in;
      end

      compare_in   = cmp_tab[duty_in];
      changed_in   = (state_in != state_ff);
      rsp_valid_in = pop || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_STOPPED;
         rsp_valid_ff <= 1'b0;
         tgt_speed_ff <= '0;
         tgt_duty_ff  <= DUTY_W'(DUTY_OFF);
         cur_speed_ff <= '0;
         cur_duty_ff  <= DUTY_W'(DUTY_OFF);
         ramp_from_ff <= '0;
         ramp_to_ff   <= '0;
         ramp_mag_ff  <= '0;
         ramp_neg_ff  <= 1'b0;
         ramp_acc_ff  <= '0;
         ramp_idx_ff  <= '0;
         ramp_long_ff <= 1'b0;
         stop_idx_ff  <= '0;
         stop_from_ff <= '0;
         stop_acc_ff  <= '0;
         duty_ff      <= DUTY_W'(DUTY_OFF);
         rpm_ff       <= '0;
         timer_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            state_ff     <= state_in;
            compare_ff   <= compare_in;
            changed_ff   <= changed_in;
            tgt_speed_ff <= tgt_speed_in;
            tgt_duty_ff  <= tgt_duty_in;
            cur_speed_ff <= cur_speed_in;
            cur_duty_ff  <= cur_duty_in;
            ramp_from_ff <= ramp_from_in;
            ramp_to_ff   <= ramp_to_in;
            ramp_mag_ff  <= ramp_mag_in;
            ramp_neg_ff  <= ramp_neg_in;
            ramp_acc_ff  <= ramp_acc_in;
            ramp_idx_ff  <= ramp_idx_in;
            ramp_long_ff <= ramp_long_in;
            stop_idx_ff  <= stop_idx_in;
            stop_from_ff <= stop_from_in;
            stop_acc_ff  <= stop_acc_in;
            duty_ff      <= duty_in;
            rpm_ff       <= rpm_in;
            timer_ff     <= timer_in;
         end
      end
   end

   // state only moves on a pop, so it doubles as the result payload
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.compare_value = compare_ff;
   assign rsp.duty_percent  = duty_ff;
   assign rsp.mode          = state_ff;
   assign rsp.mode_changed  = changed_ff;
   assign rsp.speed_now     = cur_speed_ff;
   assign rsp.rpm_value     = rpm_ff;
   assign rsp.pwm_running   = timer_ff;

endmodule

>>> tb/sv/pwm_motor_soft_ramp_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_motor_soft_ramp_controller_tb: self-checking bench for the soft ramp
// A short table of directed events, then random start, ramp, run and stop
// sessions mixed with noise. Every accepted event goes through a local model
// of the ramp sequencer. Each returned status is compared field by field.
// ----------------------------------------------------------------------------
module pwm_motor_soft_ramp_controller_tb;
   import pwmsr_pkg::*;

   localparam int PWM_PERIOD     = 1000;
   localparam int PULSES_PER_REV = 2;
   localparam int START_STEPS    = 10;
   localparam int SPEED_STEPS    = 16;

   localparam int IDLE_PERCENT    = 17;
   localparam int ITEM_TARGET     = 550;  // directed rows plus random events, all counted
   localparam int RSP_HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES   = 8;    // idle after the last result is back, before judging
   localparam int RUN_LIMIT_NS    = 1_000_000;

   // op codes the block leaves unused; they must pass through untouched
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef enum logic [MODE_W-1:0] {
      MOTOR_STOPPED   = 2'd0,
      MOTOR_RAMP_UP   = 2'd1,
      MOTOR_RUNNING   = 2'd2,
      MOTOR_RAMP_DOWN = 2'd3
   } motor_mode_type;

   typedef struct packed {
      logic [CMP_W-1:0]   compare_value;
      logic [DUTY_W-1:0]  duty;
      motor_mode_type     mode;
      logic               mode_changed;
      logic [SPEED_W-1:0] speed_now;
      logic [RPM_W-1:0]   rpm;
      logic               pwm_running;
   } motor_status_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [REQ_W-1:0]   speed;
      logic [PULSE_W-1:0] pulses;
      logic               has_status;
      motor_status_type   status;
   } directed_row_type;

   localparam motor_status_type NO_STATUS   = '0;
   localparam motor_status_type IDLE_STATUS =
      '{10'd1, 7'd100, MOTOR_STOPPED, 1'b0, 7'd0, 16'd0, 1'b0};

   // Walk the special cases: ignored events while stopped, speed clamping,
   // start and restart, a speed change mid ramp, stop from ramping up, and the
   // events that ramping down only records or ignores. Fixed statuses are
   // given where they follow straight from reset or an extreme value.
   localparam int DIRECTED_COUNT = 25;
   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{OP_SPARE_HI,   8'd0,   15'd0,     1'b1, IDLE_STATUS},
      '{OP_SPARE_LO,   8'd0,   15'd0,     1'b1, IDLE_STATUS},
      '{OP_RPM_WINDOW, 8'd0,   15'h7FFF,  1'b1,
        '{10'd1, 7'd100, MOTOR_STOPPED, 1'b0, 7'd0, 16'hFFFF, 1'b0}},
      '{OP_RPM_WINDOW, 8'd0,   15'd0,     1'b1, IDLE_STATUS},
      '{OP_RAMP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_STOP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_STOP,       8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_SET_SPEED,  8'd255, 15'd0,     1'b0, NO_STATUS},
      '{OP_SET_SPEED,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_SET_SPEED,  8'd3,   15'd0,     1'b0, NO_STATUS},
      '{OP_START,      8'd0,   15'd0,     1'b1,
        '{10'd900, 7'd10, MOTOR_RAMP_UP, 1'b1, 7'd0, 16'd0, 1'b1}},
      '{OP_START,      8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_RAMP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_SET_SPEED,  8'd100, 15'd0,     1'b0, NO_STATUS},
      '{OP_RAMP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_STOP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_STOP,       8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_SET_SPEED,  8'd50,  15'd0,     1'b0, NO_STATUS},
      '{OP_START,      8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_RAMP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_STOP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_STOP,       8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_RPM_WINDOW, 8'd0,   15'd1234,  1'b0, NO_STATUS},
      '{OP_STOP_TICK,  8'd0,   15'd0,     1'b0, NO_STATUS},
      '{OP_SET_SPEED,  8'd255, 15'h7FFF,  1'b0, NO_STATUS}
   };

   logic clock;
   logic reset;

   pwmsr_req_if req_ch ();
   pwmsr_rsp_if rsp_ch ();

   pwm_motor_soft_ramp_controller #(
      .PWM_PERIOD     (PWM_PERIOD),
      .PULSES_PER_REV (PULSES_PER_REV),
      .START_STEPS    (START_STEPS),
      .SPEED_STEPS    (SPEED_STEPS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Model state of the ramp sequencer, held at the block's widths and
   // starting from the reset values.
   motor_mode_type       mode_q          = MOTOR_STOPPED;
   logic [SPEED_W-1:0]   target_speed_q  = '0;
   logic [SPEED_W-1:0]   reached_speed_q = '0;
   logic [DUTY_W-1:0]    ramp_from_q     = '0;
   logic [DUTY_W-1:0]    ramp_to_q       = '0;
   logic [IDX_W-1:0]     ramp_step_q     = '0;
   logic                 ramp_long_q     = 1'b0;
   logic [STOP_IDX_W-1:0] fade_step_q    = '0;
   logic [DUTY_W-1:0]    fade_from_q     = '0;
   logic [DUTY_W-1:0]    duty_q          = DUTY_W'(DUTY_OFF);
   logic [RPM_W-1:0]     rpm_q           = '0;
   logic                 timer_q         = 1'b0;

   motor_status_type expected_status [$];
   int            item_count       = 0;
   int            mismatch_count   = 0;
   bit            quiet_stretch    = 1'b0;
   bit            rsp_hold_request = 1'b0;

   // Map a speed percent onto the high duty: 1 runs slowest at 90, 100 runs
   // fastest at 10, and 0 parks the pin at 100.
   function automatic int duty_for_speed(input int pct);
      if (pct == 0) return DUTY_OFF;
      if (pct > SPEED_MAX) pct = SPEED_MAX;
      return DUTY_SLOW - ((pct - 1) * (DUTY_SLOW - DUTY_FAST)) / PCT_SPAN;
   endfunction

   function automatic int duty_to_compare(input int duty);
      int cmp;
      if (duty > DUTY_OFF) duty = DUTY_OFF;
      cmp = (PWM_PERIOD * (DUTY_OFF - duty)) / DUTY_OFF;
      if (cmp < 1) cmp = 1;
      if (cmp >= PWM_PERIOD) cmp = PWM_PERIOD - 1;
      return cmp;
   endfunction

   // Apply one event to the model and return the status it should produce.
   task automatic advance_ramp_state(input logic [OP_W-1:0] op,
                                     input logic [REQ_W-1:0] speed_in,
                                     input logic [PULSE_W-1:0] pulses,
                                     output motor_status_type status);
      motor_mode_type prev_mode;
      int          pct;
      int          goal_duty;
      int          kick;
      int          held_duty;
      int          steps;
      int          next_duty;
      int          rpm_calc;
      prev_mode = mode_q;
      case (op)
         OP_SET_SPEED: begin
            pct = int'(speed_in);
            if (pct > SPEED_MAX) pct = SPEED_MAX;
            if (pct > 0 && pct < MIN_SPEED) pct = MIN_SPEED;
            target_speed_q = SPEED_W'(pct);
            // a retune only ramps while started; otherwise just record it
            if (mode_q == MOTOR_RAMP_UP || mode_q == MOTOR_RUNNING) begin
               ramp_from_q = DUTY_W'(duty_for_speed(int'(reached_speed_q)));
               ramp_to_q   = DUTY_W'(duty_for_speed(pct));
               ramp_long_q = 1'b1;
               ramp_step_q = '0;
               mode_q      = MOTOR_RAMP_UP;
            end
         end
         OP_START: begin
            if (mode_q == MOTOR_STOPPED || mode_q == MOTOR_RAMP_UP) begin
               goal_duty   = duty_for_speed(int'(target_speed_q));
               kick        = (goal_duty < DUTY_FAST) ? goal_duty : DUTY_FAST;
               mode_q      = MOTOR_RAMP_UP;
               duty_q      = DUTY_W'(kick);
               timer_q     = 1'b1;
               ramp_from_q = DUTY_W'(kick);
               ramp_to_q   = DUTY_W'(goal_duty);
               ramp_long_q = 1'b0;
               ramp_step_q = '0;
            end
         end
         OP_STOP: begin
            if (mode_q != MOTOR_STOPPED) begin
               held_duty = duty_for_speed(int'(reached_speed_q));
               if (held_duty > DUTY_SLOW) held_duty = DUTY_SLOW;
               mode_q      = MOTOR_RAMP_DOWN;
               fade_from_q = DUTY_W'(held_duty);
               duty_q      = DUTY_W'(held_duty);
               fade_step_q = STOP_IDX_W'(1);
            end
         end
         OP_RAMP_TICK: begin
            if (mode_q == MOTOR_RAMP_UP) begin
               steps       = ramp_long_q ? SPEED_STEPS : START_STEPS;
               ramp_step_q = ramp_step_q + 1'b1;
               if (int'(ramp_step_q) >= steps) begin
                  duty_q          = ramp_to_q;
                  reached_speed_q = target_speed_q;
                  mode_q          = MOTOR_RUNNING;
               end else begin
                  // truncate toward zero, as the ramp may run either way
                  next_duty = int'(ramp_from_q) +
                              ((int'(ramp_to_q) - int'(ramp_from_q)) * int'(ramp_step_q))
                              / steps;
                  if (next_duty < 1) next_duty = 1;
                  if (next_duty > DUTY_OFF) next_duty = DUTY_OFF;
                  duty_q = DUTY_W'(next_duty);
               end
            end
         end
         OP_STOP_TICK: begin
            if (mode_q == MOTOR_RAMP_DOWN) begin
               if (int'(fade_step_q) <= STOP_POINTS) begin
                  next_duty = int'(fade_from_q) +
                              ((DUTY_OFF - int'(fade_from_q)) * int'(fade_step_q))
                              / STOP_POINTS;
                  if (next_duty > DUTY_OFF) next_duty = DUTY_OFF;
                  duty_q      = DUTY_W'(next_duty);
                  fade_step_q = fade_step_q + 1'b1;
               end else begin
                  // the tick after the last fade point halts the timer
                  timer_q         = 1'b0;
                  reached_speed_q = '0;
                  rpm_q           = '0;
                  fade_step_q     = '0;
                  mode_q          = MOTOR_STOPPED;
               end
            end
         end
         OP_RPM_WINDOW: begin
            rpm_calc = (int'(pulses) * SEC_PER_MIN) / PULSES_PER_REV;
            rpm_q    = (rpm_calc > 65535) ? '1 : RPM_W'(rpm_calc);
         end
         default: ;
      endcase
      status.compare_value = CMP_W'(duty_to_compare(int'(duty_q)));
      status.duty          = duty_q;
      status.mode          = mode_q;
      status.mode_changed  = (mode_q != prev_mode);
      status.speed_now     = reached_speed_q;
      status.rpm           = rpm_q;
      status.pwm_running   = timer_q;
   endtask

   // Lean the speed towards the interesting regions: zero, the raised low
   // band, the clamped top band and full speed.
   function automatic logic [REQ_W-1:0] pick_speed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return REQ_W'($urandom_range(1, MIN_SPEED - 1));
         2:       return REQ_W'($urandom_range(SPEED_MAX + 1, 255));
         3:       return REQ_W'(SPEED_MAX);
         default: return REQ_W'($urandom_range(MIN_SPEED, SPEED_MAX));
      endcase
   endfunction

   // Include the saturation edge of the rpm conversion (about 2185 pulses).
   function automatic logic [PULSE_W-1:0] pick_pulses();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return PULSE_W'($urandom_range(2180, 2190));
         default: return PULSE_W'($urandom_range(0, 32767));
      endcase
   endfunction

   // Offer one item from the falling edge, idling at random first, and hold
   // it until the block takes it. Predict on acceptance. Returns at the next
   // falling edge without touching valid, so back-to-back items keep it high.
   task automatic offer_event(input logic [OP_W-1:0] op,
                              input logic [REQ_W-1:0] speed,
                              input logic [PULSE_W-1:0] pulses,
                              input logic has_status,
                              input motor_status_type typed_status);
      motor_status_type predicted;
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.speed_request <= speed;
      req_ch.pulse_count   <= pulses;
      do @(posedge clock); while (!req_ch.ready);
      advance_ramp_state(op, speed, pulses, predicted);
      item_count++;
      expected_status.push_back(has_status ? typed_status : predicted);
      @(negedge clock);
   endtask

   task automatic offer_random(input logic [OP_W-1:0] op);
      offer_event(op, pick_speed(), pick_pulses(), 1'b0, NO_STATUS);
   endtask

   // Drop valid and hold off until every outstanding status is back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // One well-formed session: set a speed, start, ramp up (sometimes cut
   // short), maybe retune while running, then stop and fade out. Sprinkle
   // rpm windows and stray commands along the way.
   task automatic run_motor_session();
      int ticks;
      offer_random(OP_SET_SPEED);
      offer_random(OP_START);
      ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : $urandom_range(10, 20);
      repeat (ticks) begin
         case ($urandom_range(0, 19))
            0, 1:    offer_random(OP_RPM_WINDOW);
            2:       offer_random(OP_SET_SPEED);
            3:       offer_random(OP_START);
            default: ;
         endcase
         offer_random(OP_RAMP_TICK);
      end
      if ($urandom_range(0, 2) == 0) begin
         offer_random(OP_SET_SPEED);
         repeat ($urandom_range(14, 18)) offer_random(OP_RAMP_TICK);
      end
      if ($urandom_range(0, 3) == 0) offer_random(OP_START);
      offer_random(OP_STOP);
      ticks = $urandom_range(9, 13);
      repeat (ticks) begin
         case ($urandom_range(0, 19))
            0, 1:    offer_random(OP_RPM_WINDOW);
            2:       offer_random(OP_SET_SPEED);
            3:       offer_random(OP_START);
            4:       offer_random(OP_STOP);
            default: ;
         endcase
         offer_random(OP_STOP_TICK);
      end
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Free-running clock, 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("pwm_motor_soft_ramp_controller_tb: errors");
      $finish;
   end

   // Response side: take results from the falling edge, idling at random,
   // and on request hold off for a long stretch so the queue fills and the
   // request side backs up.
   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      motor_status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual duty %0d mode %0d",
                     $time, rsp_ch.duty_percent, rsp_ch.mode);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            report_field("compare_value", want.compare_value, rsp_ch.compare_value);
            report_field("duty_percent", want.duty, rsp_ch.duty_percent);
            report_field("mode", want.mode, rsp_ch.mode);
            report_field("mode_changed", want.mode_changed, rsp_ch.mode_changed);
            report_field("speed_now", want.speed_now, rsp_ch.speed_now);
            report_field("rpm_value", want.rpm, rsp_ch.rpm_value);
            report_field("pwm_running", want.pwm_running, rsp_ch.pwm_running);
         end
      end
   end

   // Stimulus: reset, directed table, random sessions, then drain and judge.
   initial begin
      bit hold_done;
      bit drain_done;
      hold_done            = 1'b0;
      drain_done           = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.op            = '0;
      req_ch.speed_request = '0;
      req_ch.pulse_count   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int row = 0; row < DIRECTED_COUNT; row++) begin
         offer_event(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].speed,
                     DIRECTED_ROWS[row].pulses, DIRECTED_ROWS[row].has_status,
                     DIRECTED_ROWS[row].status);
      end

      while (item_count < ITEM_TARGET) begin
         // stall the response side once while requests keep coming
         if (!hold_done && item_count >= 150) begin
            rsp_hold_request = 1'b1;
            hold_done        = 1'b1;
         end
         // and pause the request side once until everything is back
         if (!drain_done && item_count >= 300) begin
            wait_for_results();
            drain_done = 1'b1;
         end
         // a stretch with neither side idling
         quiet_stretch = (item_count >= 350 && item_count < 430);
         if ($urandom_range(0, 99) < 80) begin
            run_motor_session();
         end else begin
            repeat ($urandom_range(1, 6)) offer_random(OP_W'($urandom_range(0, 7)));
         end
      end

      quiet_stretch = 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("pwm_motor_soft_ramp_controller_tb: clean");
      end else begin
         $display("pwm_motor_soft_ramp_controller_tb: errors");
      end
      $finish;
   end

endmodule
